FILE: hdl/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled during reset
`define ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`endif

FILE: hdl/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg
// types, codes and key tables of the tokenized basic detokenizer
// ----------------------------------------------------------------------------
package tbd_pkg;

  // result kinds
  localparam logic [3:0] KindToken  = 4'd0;
  localparam logic [3:0] KindChar   = 4'd1;
  localparam logic [3:0] KindEol    = 4'd2;
  localparam logic [3:0] KindLineNo = 4'd3;
  localparam logic [3:0] KindOctal  = 4'd4;
  localparam logic [3:0] KindHex    = 4'd5;
  localparam logic [3:0] KindWord   = 4'd6;
  localparam logic [3:0] KindByte   = 4'd7;
  localparam logic [3:0] KindSigned = 4'd8;
  localparam logic [3:0] KindSingle = 4'd9;
  localparam logic [3:0] KindDouble = 4'd10;
  localparam logic [3:0] KindUnk    = 4'd11;
  localparam logic [3:0] KindPrgEnd = 4'd12;
  localparam logic [3:0] KindBadHdr = 4'd13;
  localparam logic [3:0] KindStrEnd = 4'd14;

  // special bytes
  localparam logic [7:0] HdrProt  = 8'hFE;
  localparam logic [7:0] HdrPlain = 8'hFF;
  localparam logic [7:0] BColon   = 8'h3A;
  localparam logic [7:0] BElse    = 8'hA1;
  localparam logic [7:0] BRem     = 8'h8F;
  localparam logic [7:0] BQuote   = 8'hD9;
  localparam logic [7:0] BWhile   = 8'hB1;
  localparam logic [7:0] BPlus    = 8'hE9;
  localparam logic [7:0] ExpBias  = 8'd129;

  // one raw item sent from front to back: up to four results
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
  } res_t;

  typedef struct packed {
    logic [2:0]     n;     // number of results, 0..4
    res_t [3:0]     res;
  } bundle_t;

  function automatic logic [7:0] key11(input logic [3:0] i);
    case (i)
      4'd0: key11 = 8'h1E;  4'd1: key11 = 8'h1D;  4'd2: key11 = 8'hC4;
      4'd3: key11 = 8'h77;  4'd4: key11 = 8'h26;  4'd5: key11 = 8'h97;
      4'd6: key11 = 8'hE0;  4'd7: key11 = 8'h74;  4'd8: key11 = 8'h59;
      4'd9: key11 = 8'h88;  4'd10: key11 = 8'h7C;
      default: key11 = 8'h1E;
    endcase
  endfunction

  function automatic logic [7:0] key13(input logic [3:0] i);
    case (i)
      4'd0: key13 = 8'hA9;  4'd1: key13 = 8'h84;  4'd2: key13 = 8'h8D;
      4'd3: key13 = 8'hCD;  4'd4: key13 = 8'h75;  4'd5: key13 = 8'h83;
      4'd6: key13 = 8'h43;  4'd7: key13 = 8'h63;  4'd8: key13 = 8'h24;
      4'd9: key13 = 8'h83;  4'd10: key13 = 8'h19; 4'd11: key13 = 8'hF7;
      4'd12: key13 = 8'h9A;
      default: key13 = 8'hA9;
    endcase
  endfunction

endpackage

FILE: hdl/tbd_front.sv
// ----------------------------------------------------------------------------
// tbd_front
// deciphers and parses one byte a cycle, when not held by the back end, into a bundle of up to four results
// ----------------------------------------------------------------------------
module tbd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output logic             b_valid_o,
  input  logic             b_ready_i,
  output tbd_pkg::bundle_t b_data_o
);
  import tbd_pkg::*;

  localparam logic [3:0] PhHeader  = 4'd0;
  localparam logic [3:0] PhLinkLo  = 4'd1;
  localparam logic [3:0] PhLinkHi  = 4'd2;
  localparam logic [3:0] PhLineLo  = 4'd3;
  localparam logic [3:0] PhLineHi  = 4'd4;
  localparam logic [3:0] PhToken   = 4'd5;
  localparam logic [3:0] PhPrefix  = 4'd6;
  localparam logic [3:0] PhOperand = 4'd7;
  localparam logic [3:0] PhDone    = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic        dec_q, dec_d;
  logic [3:0]  r11_q, r11_d, r13_q, r13_d;
  logic [15:0] la_q, la_d;
  logic [1:0]  lac_q, lac_d;
  logic [7:0]  pre_q, pre_d;
  logic [63:0] g_q, g_d;
  logic [3:0]  oc_q, oc_d;
  logic [3:0]  lk_q, lk_d;
  logic [7:0]  ll_q, ll_d;
  logic        bv_q;
  bundle_t     bd_q, bd_d;

  logic        fire;
  assign in_ready_o = !bv_q || b_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign b_valid_o  = bv_q;
  assign b_data_o   = bd_q;

  // ieee single from mbf single
  function automatic logic [63:0] mbf_s(input logic [63:0] g);
    logic [7:0]  e;
    logic [23:0] m, q;
    logic [1:0]  rem;
    logic        up;
    e = g[31:24];
    m = {1'b1, g[22:0]};
    mbf_s = '0;
    if (e >= 8'd3) begin
      mbf_s = {32'd0, g[23], e - 8'd2, g[22:0]};
    end else if (e == 8'd2) begin
      q = m >> 1; up = m[0] && q[0];
      mbf_s = {32'd0, g[23], 7'd0, q + {23'd0, up}};
    end else if (e == 8'd1) begin
      q = m >> 2; rem = m[1:0];
      up = (rem > 2'd2) || (rem == 2'd2 && q[0]);
      mbf_s = {32'd0, g[23], 7'd0, q + {23'd0, up}};
    end
  endfunction

  // ieee double from mbf double
  function automatic logic [63:0] mbf_d(input logic [63:0] g);
    logic [7:0]  e;
    logic [52:0] q;
    logic [2:0]  rem;
    logic        up;
    e   = g[63:56];
    q   = {1'b0, g[54:3]};
    rem = g[2:0];
    up  = (rem > 3'd4) || (rem == 3'd4 && q[0]);
    mbf_d = '0;
    if (e != 8'd0) begin
      mbf_d = {g[55], ({3'd0, e} + 11'd894), 52'd0} + {11'd0, q + {52'd0, up}};
      mbf_d[63] = g[55];
    end
  endfunction

  always_comb begin
    logic [7:0] b, x;
    logic [3:0] r11, r13, need;
    logic [15:0] op;
    logic [63:0] gg;
    logic        start;  // token start on b
    phase_d = phase_q; dec_d = dec_q; r11_d = r11_q; r13_d = r13_q;
    la_d = la_q; lac_d = lac_q; pre_d = pre_q; g_d = g_q; oc_d = oc_q;
    lk_d = lk_q; ll_d = ll_q;
    bd_d = '0;
    start = 1'b0;
    b = byte_i;
    x = '0;
    r11 = (r11_q < 4'd11) ? r11_q : 4'd0;
    r13 = (r13_q < 4'd13) ? r13_q : 4'd0;
    op = '0; gg = '0; need = 4'd2;

    if (phase_q == PhHeader) begin
      if (b == HdrPlain) begin
        dec_d = 1'b0; phase_d = PhLinkLo;
      end else if (b == HdrProt) begin
        dec_d = 1'b1; phase_d = PhLinkLo;
      end else begin
        bd_d.res[0] = '{KindBadHdr, {56'd0, b}}; bd_d.n = 3'd1; phase_d = PhDone;
      end
    end else begin
      // decipher with the two rotors
      if (dec_q) begin
        x = b - (8'd11 - {4'd0, r11});
        x = x ^ key11(r11) ^ key13(r13);
        b = x + (8'd13 - {4'd0, r13});
        r11_d = (r11 == 4'd10) ? 4'd0 : r11 + 4'd1;
        r13_d = (r13 == 4'd12) ? 4'd0 : r13 + 4'd1;
      end
      case (phase_q)
        PhLinkLo: begin ll_d = b; phase_d = PhLinkHi; end
        PhLinkHi: begin
          if ((ll_q | b) == 8'd0) begin
            bd_d.res[0] = '{KindPrgEnd, 64'd0}; bd_d.n = 3'd1; phase_d = PhDone;
          end else phase_d = PhLineLo;
        end
        PhLineLo: begin ll_d = b; phase_d = PhLineHi; end
        PhLineHi: begin
          bd_d.res[0] = '{KindLineNo, {48'd0, b, ll_q}}; bd_d.n = 3'd1;
          phase_d = PhToken;
        end
        PhToken: begin
          if (lac_q == 2'd0) start = 1'b1;
          else if (lac_q == 2'd1 && la_q[7:0] == BColon) begin
            if (b == BElse) begin
              lac_d = 2'd0; la_d = '0;
              bd_d.res[0] = '{KindToken, {56'd0, BElse}}; bd_d.n = 3'd1;
            end else if (b == BRem) begin
              la_d = {BRem, BColon}; lac_d = 2'd2;
            end else begin
              lac_d = 2'd0; la_d = '0;
              bd_d.res[0] = '{KindChar, {56'd0, BColon}}; bd_d.n = 3'd1;
              start = 1'b1;
            end
          end else if (lac_q == 2'd1) begin
            lac_d = 2'd0; la_d = '0;
            bd_d.res[0] = '{KindToken, {56'd0, BWhile}}; bd_d.n = 3'd1;
            start = (b != BPlus);
          end else begin
            lac_d = 2'd0; la_d = '0;
            if (b == BQuote) begin
              bd_d.res[0] = '{KindToken, {56'd0, BQuote}}; bd_d.n = 3'd1;
            end else begin
              bd_d.res[0] = '{KindChar, {56'd0, BColon}};
              bd_d.res[1] = '{KindToken, {56'd0, BRem}};
              bd_d.n = 3'd2; start = 1'b1;
            end
          end
        end
        PhPrefix: begin
          op = {pre_q, b};
          if ((op >= 16'hFD81 && op <= 16'hFD8B) || (op >= 16'hFE81 && op <= 16'hFEA8)
              || (op >= 16'hFF81 && op <= 16'hFFA5))
            bd_d.res[0] = '{KindToken, {48'd0, op}};
          else
            bd_d.res[0] = '{KindUnk, {48'd0, op}};
          bd_d.n = 3'd1; phase_d = PhToken;
        end
        PhOperand: begin
          gg = g_q | ({56'd0, b} << {oc_q[2:0], 3'b000});
          g_d = gg; oc_d = oc_q + 4'd1;
          case (lk_q)
            KindByte:   need = 4'd1;
            KindSingle: need = 4'd4;
            KindDouble: need = 4'd8;
            default:    need = 4'd2;
          endcase
          if (oc_d >= need) begin
            bd_d.res[0].kind = lk_q;
            case (lk_q)
              KindOctal, KindSigned: bd_d.res[0].value = {{48{gg[15]}}, gg[15:0]};
              KindByte:   bd_d.res[0].value = {56'd0, gg[7:0]};
              KindSingle: bd_d.res[0].value = mbf_s(gg);
              KindDouble: bd_d.res[0].value = mbf_d(gg);
              default:    bd_d.res[0].value = {48'd0, gg[15:0]};
            endcase
            bd_d.n = 3'd1; phase_d = PhToken;
          end
        end
        default: ;
      endcase
      // token start appends after held results
      if (start) begin
        if (b >= 8'hFD) begin
          pre_d = b; phase_d = PhPrefix;
        end else if (b == BColon || b == BWhile) begin
          la_d = {8'd0, b}; lac_d = 2'd1;
        end else begin
          lk_d = lk_q;
          case (b) inside
            [8'h11:8'h1B], [8'h81:8'hF4]: begin
              bd_d.res[bd_d.n[1:0]] = '{KindToken, {56'd0, b}}; bd_d.n = bd_d.n + 3'd1;
            end
            [8'h20:8'h7E]: begin
              bd_d.res[bd_d.n[1:0]] = '{KindChar, {56'd0, b}}; bd_d.n = bd_d.n + 3'd1;
            end
            8'h00: begin
              bd_d.res[bd_d.n[1:0]] = '{KindEol, 64'd0}; bd_d.n = bd_d.n + 3'd1;
              phase_d = PhLinkLo;
            end
            8'h0B: lk_d = KindOctal;
            8'h0C: lk_d = KindHex;
            8'h0E: lk_d = KindWord;
            8'h0F: lk_d = KindByte;
            8'h1C: lk_d = KindSigned;
            8'h1D: lk_d = KindSingle;
            8'h1F: lk_d = KindDouble;
            default: begin
              bd_d.res[bd_d.n[1:0]] = '{KindUnk, {56'd0, b}}; bd_d.n = bd_d.n + 3'd1;
            end
          endcase
          if (b == 8'h0B || b == 8'h0C || b == 8'h0E || b == 8'h0F || b == 8'h1C ||
              b == 8'h1D || b == 8'h1F) begin
            g_d = '0; oc_d = '0; phase_d = PhOperand;
          end
        end
      end
    end

    // end of file: flush lookahead, stream end, reset
    if (last_i) begin
      if (lac_d == 2'd1 && la_d[7:0] == BColon) begin
        bd_d.res[bd_d.n[1:0]] = '{KindChar, {56'd0, BColon}}; bd_d.n = bd_d.n + 3'd1;
      end else if (lac_d == 2'd1) begin
        bd_d.res[bd_d.n[1:0]] = '{KindToken, {56'd0, BWhile}}; bd_d.n = bd_d.n + 3'd1;
      end else if (lac_d == 2'd2) begin
        bd_d.res[bd_d.n[1:0]] = '{KindChar, {56'd0, BColon}}; bd_d.n = bd_d.n + 3'd1;
        bd_d.res[bd_d.n[1:0]] = '{KindToken, {56'd0, BRem}}; bd_d.n = bd_d.n + 3'd1;
      end
      bd_d.res[bd_d.n[1:0]] = '{KindStrEnd, 64'd0}; bd_d.n = bd_d.n + 3'd1;
      phase_d = PhHeader; dec_d = 1'b0; r11_d = '0; r13_d = '0; la_d = '0;
      lac_d = '0; pre_d = '0; g_d = '0; oc_d = '0; lk_d = '0; ll_d = '0;
    end
  end

  // state and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader; dec_q <= 1'b0; r11_q <= '0; r13_q <= '0;
      la_q <= '0; lac_q <= '0; pre_q <= '0; g_q <= '0; oc_q <= '0;
      lk_q <= '0; ll_q <= '0; bv_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d; dec_q <= dec_d; r11_q <= r11_d; r13_q <= r13_d;
        la_q <= la_d; lac_q <= lac_d; pre_q <= pre_d; g_q <= g_d; oc_q <= oc_d;
        lk_q <= lk_d; ll_q <= ll_d;
        bv_q <= (bd_d.n != 3'd0);
      end else if (b_ready_i) begin
        bv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) bd_q <= bd_d;
  end

endmodule

FILE: hdl/tbd_back.sv
// ----------------------------------------------------------------------------
// tbd_back
// two-entry bundle queue and serialiser of results onto the output stream
// ----------------------------------------------------------------------------
module tbd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             b_valid_i,
  output logic             b_ready_o,
  input  tbd_pkg::bundle_t b_data_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [3:0]       m_kind_o,
  output logic [63:0]      m_value_o,
  output logic             m_last_o
);
  import tbd_pkg::*;

  bundle_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  logic       push, pop;
  bundle_t    head;

  assign head      = mem_q[rp_q];
  assign b_ready_o = (cnt_q != 2'd2);
  assign push      = b_valid_i && b_ready_o;
  assign m_valid_o = (cnt_q != 2'd0);
  assign m_kind_o  = head.res[idx_q].kind;
  assign m_value_o = head.res[idx_q].value;
  assign m_last_o  = ({1'b0, idx_q} + 3'd1 == head.n);
  assign pop       = m_valid_o && m_ready_i && m_last_o;

  // queue pointers and result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (m_valid_o && m_ready_i) idx_q <= pop ? 2'd0 : idx_q + 2'd1;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= b_data_i;
  end

endmodule

FILE: hdl/tokenized_basic_detokenizer_core.sv
// ----------------------------------------------------------------------------
// tokenized_basic_detokenizer_core
// streaming detokenizer of tokenized basic program files
// ----------------------------------------------------------------------------
// Takes one file byte per cycle and gives typed results (token, character,
// literal, float bits, markers) on the master stream, one per cycle while
// m_axis_tready is high. Each byte is deciphered (when protected) and parsed
// by the front end, which registers a bundle of up to four results for a
// two-entry queue; the back end sends one result a cycle, and the input rate
// is one byte a cycle while output keeps up. Header FF is plain, FE
// protected; m_axis_tlast marks the last result of a byte.
module tokenized_basic_detokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // kind[3:0], value[67:4], zero[71:68]
  output logic        m_axis_tlast
);
  import tbd_pkg::*;

  logic        bv, br;
  bundle_t     bd;
  logic [3:0]  kind;
  logic [63:0] value;

  tbd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .b_valid_o(bv), .b_ready_i(br), .b_data_o(bd)
  );

  tbd_back u_back (
    .clk_i, .rst_ni,
    .b_valid_i(bv), .b_ready_o(br), .b_data_i(bd),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_kind_o(kind), .m_value_o(value), .m_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, value, kind};

endmodule

FILE: hdl/tbd_checker.sv
// ----------------------------------------------------------------------------
// tbd_checker
// port-level checks of the detokenizer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import tbd_pkg::*;

  // kind never above stream end
  `ASSERT_RST(a_kind, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[3:0] <= KindStrEnd, "bad kind")
  // stream end is always the last result of its byte
  `ASSERT_RST(a_end, clk_i, rst_ni,
              m_axis_tvalid && m_axis_tdata[3:0] == KindStrEnd |-> m_axis_tlast, "end not last")
  // stalled result holds
  `ASSERT_RST(a_hold, clk_i, rst_ni,
              m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result moved")
  // pad bits zero
  `ASSERT_RST(a_pad, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[71:68] == 4'd0, "pad set")
endmodule

bind tokenized_basic_detokenizer_core tbd_checker u_chk (.*);
